>>> design/btd_pkg.sv
package btd_pkg;

    // Frame geometry and ring size.
    localparam int IMAGE_WIDTH  = 640;
    localparam int IMAGE_HEIGHT = 360;
    localparam int MAX_FRAMES   = 64;

    localparam int FRAME_PIXELS = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int STORE_DEPTH  = MAX_FRAMES * FRAME_PIXELS;

    localparam int PIXEL_W = 24;

    // Counter and index widths; a width never drops below one bit.
    localparam int COL_W  = (IMAGE_WIDTH > 1) ? $clog2(IMAGE_WIDTH) : 1;
    localparam int ROW_W  = (IMAGE_HEIGHT > 1) ? $clog2(IMAGE_HEIGHT) : 1;
    localparam int ROWN_W = $clog2(IMAGE_HEIGHT + 1);
    localparam int POS_W  = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
    localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // Configuration port.
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_BANDS = 2'd2;

    // Configuration after clamping to the legal ranges.
    typedef struct packed {
        logic [CNT_W-1:0] frames;
        logic [CNT_W-1:0] bands;
        logic             reverse;
    } btd_cfg_t;

    // Status and table write port of the band sequencer.
    typedef struct packed {
        logic              busy;
        logic              tbl_we;
        logic [ROW_W-1:0]  tbl_addr;
        logic [SLOT_W-1:0] tbl_data;
        logic              wfm_load;
        logic [SLOT_W-1:0] wfm_value;
    } btd_seq_t;

endpackage

>>> design/btd_ram.sv
module btd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/btd_band_seq.sv
module btd_band_seq (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        restart,
    input  btd_pkg::btd_cfg_t           cfg_eff,
    input  logic [btd_pkg::SLOT_W-1:0]  write_frame,
    output btd_pkg::btd_seq_t           seq
);
    import btd_pkg::*;

    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_DIV    = 3'd1;
    localparam logic [2:0] ST_SWEEP  = 3'd2;
    localparam logic [2:0] ST_SETTLE = 3'd3;
    localparam logic [2:0] ST_RUN    = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [ROWN_W-1:0] rem_h_reg, rem_h_next;
    logic [ROWN_W-1:0] quo_h_reg, quo_h_next;
    logic [CNT_W-1:0]  rem_f_reg, rem_f_next;
    logic [CNT_W-1:0]  step_reg, step_next;
    logic [SLOT_W-1:0] rem_w_reg, rem_w_next;
    logic [ROW_W-1:0]  y_reg, y_next;
    logic [CNT_W-1:0]  band_reg, band_next;
    logic [ROWN_W-1:0] left_reg, left_next;
    logic [SLOT_W-1:0] off_reg, off_next;

    logic              take_h, take_f, take_w;
    logic [CNT_W-1:0]  band_inc;
    logic [ROWN_W-1:0] size_first, size_inc;
    logic [CNT_W:0]    off_sum;
    logic [SLOT_W-1:0] off_adv;

    // Repeated subtraction gives rows per band, the frame step and the
    // write slot modulo the ring size, all in one loop.
    assign take_h = int'(rem_h_reg) >= int'(cfg_eff.bands);
    assign take_f = int'(rem_f_reg) >= int'(cfg_eff.bands);
    assign take_w = int'(rem_w_reg) >= int'(cfg_eff.frames);

    // The remainder of the row division is the number of taller bands.
    assign size_first = (rem_h_reg != '0) ? quo_h_reg + 1'b1 : quo_h_reg;
    assign band_inc   = band_reg + 1'b1;
    assign size_inc   = (int'(band_inc) < int'(rem_h_reg)) ? quo_h_reg + 1'b1 : quo_h_reg;

    assign off_sum = (CNT_W + 1)'(off_reg) + (CNT_W + 1)'(step_reg);
    assign off_adv = (off_sum >= (CNT_W + 1)'(cfg_eff.frames))
                   ? SLOT_W'(off_sum - (CNT_W + 1)'(cfg_eff.frames))
                   : SLOT_W'(off_sum);

    always_comb begin
        state_next = state_reg;
        rem_h_next = rem_h_reg;
        quo_h_next = quo_h_reg;
        rem_f_next = rem_f_reg;
        step_next  = step_reg;
        rem_w_next = rem_w_reg;
        y_next     = y_reg;
        band_next  = band_reg;
        left_next  = left_reg;
        off_next   = off_reg;

        seq.busy      = (state_reg != ST_RUN);
        seq.tbl_we    = 1'b0;
        seq.tbl_addr  = cfg_eff.reverse ? ROW_W'(IMAGE_HEIGHT - 1) - y_reg : y_reg;
        seq.tbl_data  = off_reg;
        seq.wfm_load  = 1'b0;
        seq.wfm_value = rem_w_reg;

        unique case (state_reg)
            ST_LOAD: begin
                rem_h_next = ROWN_W'(IMAGE_HEIGHT);
                quo_h_next = '0;
                rem_f_next = cfg_eff.frames;
                step_next  = '0;
                rem_w_next = write_frame;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (take_h) begin
                    rem_h_next = rem_h_reg - ROWN_W'(cfg_eff.bands);
                    quo_h_next = quo_h_reg + 1'b1;
                end
                if (take_f) begin
                    rem_f_next = rem_f_reg - cfg_eff.bands;
                    step_next  = step_reg + 1'b1;
                end
                if (take_w) begin
                    rem_w_next = rem_w_reg - SLOT_W'(cfg_eff.frames);
                end
                if (!take_h && !take_f && !take_w) begin
                    seq.wfm_load = 1'b1;
                    y_next       = '0;
                    band_next    = '0;
                    left_next    = size_first;
                    off_next     = '0;
                    state_next   = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                seq.tbl_we = 1'b1;
                if (left_reg == ROWN_W'(1)) begin
                    band_next = band_inc;
                    left_next = size_inc;
                    off_next  = off_adv;
                end else begin
                    left_next = left_reg - 1'b1;
                end
                if (y_reg == ROW_W'(IMAGE_HEIGHT - 1)) begin
                    state_next = ST_SETTLE;
                end else begin
                    y_next = y_reg + 1'b1;
                end
            end
            ST_SETTLE: begin
                state_next = ST_RUN;
            end
            ST_RUN: begin
                state_next = ST_RUN;
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase

        if (restart) begin
            state_next = ST_LOAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
        rem_h_reg <= rem_h_next;
        quo_h_reg <= quo_h_next;
        rem_f_reg <= rem_f_next;
        step_reg  <= step_next;
        rem_w_reg <= rem_w_next;
        y_reg     <= y_next;
        band_reg  <= band_next;
        left_reg  <= left_next;
        off_reg   <= off_next;
    end

endmodule

>>> design/banded_video_time_displacement_core.sv
// A result passes the read stage and then the output register. One pixel per cycle, set by the
// one write and one read port of the frame store, while m_ready and the sequencer do not stall.
// Reset (synchronous, aresetn low) clears counters, slot flags and the output; the frame store is
// not swept, written-slot flags stand in for its zero contents. After reset and after every
// configuration write the row table is rebuilt, and no pixel is taken while that runs.
module banded_video_time_displacement_core (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_we,
    input  logic [btd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [btd_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [btd_pkg::PIXEL_W-1:0]     s_pixel_in,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [btd_pkg::PIXEL_W-1:0]     m_pixel_out,
    output logic                            m_end_of_frame
);
    import btd_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers and their clamped, effective values.
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] frame_count_reg, frame_count_next;
    logic [CFG_DATA_W-1:0] band_count_reg, band_count_next;
    logic                  reverse_reg, reverse_next;
    btd_cfg_t              cfg_eff;
    logic [CNT_W-1:0]      bands_raw;

    always_comb begin
        frame_count_next = frame_count_reg;
        band_count_next  = band_count_reg;
        reverse_next     = reverse_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_FRAME_COUNT:   frame_count_next = cfg_data;
                REG_BAND_COUNT:    band_count_next  = cfg_data;
                REG_REVERSE_BANDS: reverse_next     = cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // A zero count behaves as one. The frame count saturates at the ring
    // size, and the band count at the frame count and the image height.
    always_comb begin
        if (frame_count_reg == '0) begin
            cfg_eff.frames = CNT_W'(1);
        end else if (int'(frame_count_reg) > MAX_FRAMES) begin
            cfg_eff.frames = CNT_W'(MAX_FRAMES);
        end else begin
            cfg_eff.frames = CNT_W'(frame_count_reg);
        end

        if (band_count_reg == '0) begin
            bands_raw = CNT_W'(1);
        end else if (int'(band_count_reg) > MAX_FRAMES) begin
            bands_raw = CNT_W'(MAX_FRAMES);
        end else begin
            bands_raw = CNT_W'(band_count_reg);
        end

        cfg_eff.bands = bands_raw;
        if (int'(cfg_eff.bands) > int'(cfg_eff.frames)) begin
            cfg_eff.bands = cfg_eff.frames;
        end
        if (int'(cfg_eff.bands) > IMAGE_HEIGHT) begin
            cfg_eff.bands = CNT_W'(IMAGE_HEIGHT);
        end

        cfg_eff.reverse = reverse_reg;
    end

    // ------------------------------------------------------------------
    // Band sequencer. It holds the channel off while it works out the
    // band geometry and writes one frame offset per image row into the
    // row table.
    // ------------------------------------------------------------------
    btd_seq_t          seq;
    logic [SLOT_W-1:0] wf_reg, wf_next;

    btd_band_seq u_band_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .restart     (cfg_we),
        .cfg_eff     (cfg_eff),
        .write_frame (wf_reg),
        .seq         (seq)
    );

    // ------------------------------------------------------------------
    // Raster position counters.
    // ------------------------------------------------------------------
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             s_accept;
    logic             col_last, row_last, frame_last;

    assign s_accept   = s_valid && s_ready;
    assign col_last   = (col_reg == COL_W'(IMAGE_WIDTH - 1));
    assign row_last   = (row_reg == ROW_W'(IMAGE_HEIGHT - 1));
    assign frame_last = (pos_reg == POS_W'(FRAME_PIXELS - 1));

    // ------------------------------------------------------------------
    // Row table: offset in frames for the band of each row. It is read at
    // the next row every cycle, so its output always matches row_reg.
    // ------------------------------------------------------------------
    logic [SLOT_W-1:0] tbl_rdata;

    btd_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (IMAGE_HEIGHT)
    ) u_row_table (
        .aclk  (aclk),
        .we    (seq.tbl_we),
        .waddr (seq.tbl_addr),
        .wdata (seq.tbl_data),
        .re    (1'b1),
        .raddr (row_next),
        .rdata (tbl_rdata)
    );

    // ------------------------------------------------------------------
    // Write slot bookkeeping. wf_reg is the slot written now; wf_mod_reg
    // is the same slot reduced modulo the frame count, which differs only
    // while a shrunken ring leaves the write slot out of range.
    // ------------------------------------------------------------------
    logic [SLOT_W-1:0]     wf_mod_reg, wf_mod_next;
    logic [ADDR_W-1:0]     wbase_reg, wbase_next;
    logic [CNT_W-1:0]      wf_inc;
    logic [SLOT_W-1:0]     wf_adv;
    logic [MAX_FRAMES-1:0] full_reg, full_next;

    assign wf_inc = CNT_W'(wf_mod_reg) + 1'b1;
    assign wf_adv = (wf_inc == cfg_eff.frames) ? '0 : SLOT_W'(wf_inc);

    // ------------------------------------------------------------------
    // Read slot and frame store addresses for the pixel on the input.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]  rd_slot_wide;
    logic [SLOT_W-1:0] rd_slot;
    logic [ADDR_W-1:0] rd_addr, wr_addr;

    assign rd_slot_wide = CNT_W'(wf_mod_reg)
                        + ((wf_mod_reg < tbl_rdata) ? cfg_eff.frames : CNT_W'(0))
                        - CNT_W'(tbl_rdata);
    assign rd_slot = SLOT_W'(rd_slot_wide);
    assign rd_addr = ADDR_W'(rd_slot) * ADDR_W'(FRAME_PIXELS) + ADDR_W'(pos_reg);
    assign wr_addr = wbase_reg + ADDR_W'(pos_reg);

    // Every transfer writes the live pixel and reads the displaced one at
    // the same position in the same cycle.
    logic [PIXEL_W-1:0] store_rdata;

    btd_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (STORE_DEPTH)
    ) u_frame_store (
        .aclk  (aclk),
        .we    (s_accept),
        .waddr (wr_addr),
        .wdata (s_pixel_in),
        .re    (s_accept),
        .raddr (rd_addr),
        .rdata (store_rdata)
    );

    // ------------------------------------------------------------------
    // Pipeline: the read stage waits for the memory data, the output
    // register holds a finished result until m_ready takes it. A read of
    // the slot being written forwards the live pixel; a read of a slot
    // that has never held a whole frame returns black, as after reset.
    // ------------------------------------------------------------------
    logic               p1_valid_reg, p1_valid_next;
    logic               p1_fwd_reg, p1_fwd_next;
    logic               p1_full_reg, p1_full_next;
    logic               p1_eof_reg, p1_eof_next;
    logic [PIXEL_W-1:0] p1_pixel_reg, p1_pixel_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_eof_reg, out_eof_next;
    logic [PIXEL_W-1:0] out_pixel_reg, out_pixel_next;
    logic               p1_adv;

    assign p1_adv  = p1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !seq.busy && (!p1_valid_reg || p1_adv);

    always_comb begin
        col_next       = col_reg;
        row_next       = row_reg;
        pos_next       = pos_reg;
        wf_next        = wf_reg;
        wf_mod_next    = wf_mod_reg;
        wbase_next     = wbase_reg;
        full_next      = full_reg;
        p1_valid_next  = p1_valid_reg;
        p1_fwd_next    = p1_fwd_reg;
        p1_full_next   = p1_full_reg;
        p1_eof_next    = p1_eof_reg;
        p1_pixel_next  = p1_pixel_reg;
        out_valid_next = out_valid_reg;
        out_eof_next   = out_eof_reg;
        out_pixel_next = out_pixel_reg;

        if (seq.wfm_load) begin
            wf_mod_next = seq.wfm_value;
        end

        if (s_accept) begin
            if (col_last) begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
            pos_next = frame_last ? '0 : pos_reg + 1'b1;

            // The slot just finished now holds a whole frame; writing
            // moves on to the next slot of the ring.
            if (frame_last) begin
                full_next[wf_reg] = 1'b1;
                wf_next           = wf_adv;
                wf_mod_next       = wf_adv;
                wbase_next        = ADDR_W'(wf_adv) * ADDR_W'(FRAME_PIXELS);
            end

            p1_fwd_next   = (rd_slot == wf_reg);
            p1_full_next  = full_reg[rd_slot];
            p1_eof_next   = frame_last;
            p1_pixel_next = s_pixel_in;
        end

        if (s_accept) begin
            p1_valid_next = 1'b1;
        end else if (p1_adv) begin
            p1_valid_next = 1'b0;
        end

        if (p1_adv) begin
            out_valid_next = 1'b1;
            out_eof_next   = p1_eof_reg;
            if (p1_fwd_reg) begin
                out_pixel_next = p1_pixel_reg;
            end else if (p1_full_reg) begin
                out_pixel_next = store_rdata;
            end else begin
                out_pixel_next = '0;
            end
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg <= CFG_DATA_W'(40);
            band_count_reg  <= CFG_DATA_W'(40);
            reverse_reg     <= 1'b0;
            col_reg         <= '0;
            row_reg         <= '0;
            pos_reg         <= '0;
            wf_reg          <= '0;
            wf_mod_reg      <= '0;
            wbase_reg       <= '0;
            full_reg        <= '0;
            p1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            frame_count_reg <= frame_count_next;
            band_count_reg  <= band_count_next;
            reverse_reg     <= reverse_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            pos_reg         <= pos_next;
            wf_reg          <= wf_next;
            wf_mod_reg      <= wf_mod_next;
            wbase_reg       <= wbase_next;
            full_reg        <= full_next;
            p1_valid_reg    <= p1_valid_next;
            out_valid_reg   <= out_valid_next;
        end
        p1_fwd_reg    <= p1_fwd_next;
        p1_full_reg   <= p1_full_next;
        p1_eof_reg    <= p1_eof_next;
        p1_pixel_reg  <= p1_pixel_next;
        out_eof_reg   <= out_eof_next;
        out_pixel_reg <= out_pixel_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_pixel_out    = out_pixel_reg;
    assign m_end_of_frame = out_eof_reg;

`ifndef SYNTHESIS
    // No pixel may enter while the row table is being rebuilt.
    a_no_transfer_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        seq.busy |-> !s_ready)
        else $error("pixel transfer allowed while the row table is rebuilt");

    // Once the sequencer is done, the reduced write slot lies inside the ring.
    a_slot_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        !seq.busy |-> (CNT_W'(wf_mod_reg) < cfg_eff.frames))
        else $error("reduced write slot outside the ring");

    // Completing a frame marks its slot as holding a whole frame.
    a_slot_marked_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && frame_last) |=> full_reg[$past(wf_reg)])
        else $error("finished slot not marked as written");
`endif

endmodule
